// ===== rtl/ruseq_pkg.sv =====
// Package for the refrigeration unit sequencer.
// Holds timer and hysteresis constants, register indexes and the result word layout.
// No dependencies.
`default_nettype none

package ruseq_pkg;

  localparam int TEMP_HYST   = 2;
  localparam int TIMER_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int TEMP_W      = 8;
  localparam int OUT_BYTES_W = 8;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_HEAT_MODE   = 3'd1,
    REG_RUN_ENABLE  = 3'd2,
    REG_FAN_CYCLE   = 3'd3,
    REG_MAX_RUN     = 3'd4,
    REG_RECOVERY    = 3'd5,
    REG_VALVE_LEAD  = 3'd6,
    REG_START_DELAY = 3'd7
  } cfg_reg_t;

  // Result word, lowest bit last.
  typedef struct packed {
    logic unit_active;
    logic temp_reached;
    logic heater_on;
    logic valve_on;
    logic fan_on;
    logic compressor_on;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/refrigeration_unit_sequencer_unit.sv =====
// Top level of the refrigeration unit sequencer: hysteresis flag, fan cycling,
// start delay, run cap and recovery, all updated once per accepted tick word.
// Depends on ruseq_pkg.
`default_nettype none

// Channel   Direction  Payload (low bit first)                         Handshake
// in_       slave      temperature[7:0] signed                         tvalid/tready
// out_      master     compressor, fan, valve, heater, reached, active tvalid/tready
// cfg_      write      index[2:0], wdata[15:0]                         wen only
//
// One tick word per clock unless out_ stalls: the state update and the result
// pass through the sequencer logic into the result register, so a word accepted at
// one edge shows on out_ after that edge. The result register parts the two
// sides; in_tready drops only while a result waits and out_tready is low.
// Reset (synchronous, rst_n low) clears all state but the result word and loads the register defaults.

module refrigeration_unit_sequencer_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [ruseq_pkg::TEMP_W-1:0]        in_tdata,    // [7:0] temperature
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [0] compressor_on [1] fan_on [2] valve_on [3] heater_on [4] temp_reached
  // [5] unit_active [7:6] zero
  output logic [ruseq_pkg::OUT_BYTES_W-1:0]   out_tdata,
  input  wire                                 cfg_wen,
  input  wire  [ruseq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ruseq_pkg::CFG_WIDTH-1:0]     cfg_wdata
);
  import ruseq_pkg::*;

  // Configuration registers.
  logic signed [7:0] setpoint_r;
  logic              heat_mode_r;
  logic              run_enable_r;
  timer_t            fan_cycle_r, max_run_r, recovery_r, valve_lead_r, start_delay_r;

  // Sequencer state.
  logic   reached_r, active_r, comp_r, fan_r, valve_r, heater_r, mode_seen_r;
  timer_t fan_cnt_r, start_cnt_r, run_cnt_r, recover_cnt_r;

  logic   reached_nxt, active_nxt, comp_nxt, fan_nxt, valve_nxt, heater_nxt, mode_seen_nxt;
  timer_t fan_cnt_nxt, start_cnt_nxt, run_cnt_nxt, recover_cnt_nxt;

  // Result register.
  logic      out_valid_r;
  out_word_t out_word_r, out_word_nxt;

  logic in_fire;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BYTES_W - $bits(out_word_t)){1'b0}}, out_word_r};

  // Thresholds one bit wider than the setpoint so they never wrap.
  logic signed [8:0] temp_x, sp_x, sp_hi, sp_lo;
  assign temp_x = {in_tdata[TEMP_W-1], in_tdata};
  assign sp_x   = {setpoint_r[7], setpoint_r};
  assign sp_hi  = sp_x + 9'(TEMP_HYST);
  assign sp_lo  = sp_x - 9'(TEMP_HYST);

  always_comb begin
    logic run_start;
    reached_nxt     = reached_r;
    active_nxt      = active_r;
    comp_nxt        = comp_r;
    fan_nxt         = fan_r;
    valve_nxt       = valve_r;
    heater_nxt      = heater_r;
    mode_seen_nxt   = mode_seen_r;
    fan_cnt_nxt     = fan_cnt_r;
    start_cnt_nxt   = start_cnt_r;
    run_cnt_nxt     = run_cnt_r;
    recover_cnt_nxt = recover_cnt_r;
    run_start       = 1'b0;

    // Hysteresis flag, cooling or heating sense.
    if (!heat_mode_r) begin
      if (temp_x <= sp_x)      reached_nxt = 1'b1;
      else if (temp_x > sp_hi) reached_nxt = 1'b0;
    end else begin
      if (temp_x >= sp_x)      reached_nxt = 1'b1;
      else if (temp_x < sp_lo) reached_nxt = 1'b0;
    end

    // Toggle the condenser fan while the compressor rests.
    if (active_r && !comp_r && reached_nxt) begin
      if (fan_cnt_r < fan_cycle_r) begin
        fan_cnt_nxt = fan_cnt_r + 1'b1;
      end else begin
        fan_cnt_nxt = '0;
        fan_nxt     = !fan_r;
      end
    end

    if (run_enable_r) begin
      if (heat_mode_r != mode_seen_r) begin
        // Mode change: take the new mode and drop out.
        mode_seen_nxt = heat_mode_r;
        start_cnt_nxt = '0;
        active_nxt    = 1'b0;
        comp_nxt      = 1'b0;
        fan_nxt       = 1'b0;
      end else begin
        if (active_r) begin
          if (run_cnt_r < max_run_r)           run_cnt_nxt     = run_cnt_r + 1'b1;
          else if (recover_cnt_r < recovery_r) recover_cnt_nxt = recover_cnt_r + 1'b1;
          else                                 run_start       = 1'b1;
        end else begin
          run_start = 1'b1;
        end

        // Start sequence: count the delay, start the compressor at its end, set valve and heater at the lead point.
        if (run_start) begin
          if (start_cnt_r < start_delay_r) start_cnt_nxt = start_cnt_r + 1'b1;
          if (start_cnt_nxt == start_delay_r && !reached_nxt) begin
            comp_nxt        = 1'b1;
            fan_nxt         = 1'b1;
            start_cnt_nxt   = '0;
            run_cnt_nxt     = '0;
            recover_cnt_nxt = '0;
            active_nxt      = 1'b1;
          end else if (valve_lead_r <= start_delay_r &&
                       start_cnt_nxt == start_delay_r - valve_lead_r) begin
            valve_nxt  = heat_mode_r;
            heater_nxt = !heat_mode_r;
          end
        end

        // Cap the run, or stop once the temperature is reached.
        if (active_r && (run_cnt_nxt == max_run_r || reached_nxt)) comp_nxt = 1'b0;
      end
    end else if (active_r) begin
      // Disabled while engaged: stop all but the valve.
      start_cnt_nxt = '0;
      active_nxt    = 1'b0;
      comp_nxt      = 1'b0;
      fan_nxt       = 1'b0;
      heater_nxt    = 1'b0;
    end

    out_word_nxt.compressor_on = comp_nxt;
    out_word_nxt.fan_on        = fan_nxt;
    out_word_nxt.valve_on      = valve_nxt;
    out_word_nxt.heater_on     = heater_nxt;
    out_word_nxt.temp_reached  = reached_nxt;
    out_word_nxt.unit_active   = active_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= 8'sd4;
      heat_mode_r   <= 1'b0;
      run_enable_r  <= 1'b1;
      fan_cycle_r   <= TIMER_WIDTH'(300);
      max_run_r     <= TIMER_WIDTH'(3600);
      recovery_r    <= TIMER_WIDTH'(300);
      valve_lead_r  <= TIMER_WIDTH'(10);
      start_delay_r <= TIMER_WIDTH'(180);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:    setpoint_r    <= cfg_wdata[7:0];
        REG_HEAT_MODE:   heat_mode_r   <= cfg_wdata[0];
        REG_RUN_ENABLE:  run_enable_r  <= cfg_wdata[0];
        REG_FAN_CYCLE:   fan_cycle_r   <= TIMER_WIDTH'(cfg_wdata);
        REG_MAX_RUN:     max_run_r     <= TIMER_WIDTH'(cfg_wdata);
        REG_RECOVERY:    recovery_r    <= TIMER_WIDTH'(cfg_wdata);
        REG_VALVE_LEAD:  valve_lead_r  <= TIMER_WIDTH'(cfg_wdata);
        REG_START_DELAY: start_delay_r <= TIMER_WIDTH'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Advance the state once per accepted word; hold the result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r     <= 1'b0;
      active_r      <= 1'b0;
      comp_r        <= 1'b0;
      fan_r         <= 1'b0;
      valve_r       <= 1'b0;
      heater_r      <= 1'b0;
      mode_seen_r   <= 1'b0;
      fan_cnt_r     <= '0;
      start_cnt_r   <= '0;
      run_cnt_r     <= '0;
      recover_cnt_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        reached_r     <= reached_nxt;
        active_r      <= active_nxt;
        comp_r        <= comp_nxt;
        fan_r         <= fan_nxt;
        valve_r       <= valve_nxt;
        heater_r      <= heater_nxt;
        mode_seen_r   <= mode_seen_nxt;
        fan_cnt_r     <= fan_cnt_nxt;
        start_cnt_r   <= start_cnt_nxt;
        run_cnt_r     <= run_cnt_nxt;
        recover_cnt_r <= recover_cnt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_word_r <= out_word_nxt;
  end

  // The compressor only runs while the cycle is engaged.
  a_comp_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r |-> active_r) else $error("compressor on while unit not engaged");

  // An accepted word always leaves a result pending.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r) else $error("accepted word produced no result");

  // The result word mirrors the state that was computed along with it.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_word_r.compressor_on == comp_r && out_word_r.unit_active == active_r))
    else $error("result word differs from sequencer state");

  // A cleared enable disengages the unit on the next word.
  a_disable_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !run_enable_r) |=> !active_r) else $error("unit stayed engaged while disabled");

endmodule

`default_nettype wire

// ===== bench/tb_refrigeration_unit_sequencer_unit.sv =====
// Self-checking bench for refrigeration_unit_sequencer_unit: tick words with temperature
// samples are predicted one by one and the drive and status word is checked.
// Depends on ruseq_pkg and the RTL top level.
`default_nettype none

module tb_refrigeration_unit_sequencer_unit;
  import ruseq_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [TEMP_W-1:0]     in_tdata = '0;    // [7:0] temperature
  logic                  out_tready = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_WIDTH-1:0]  cfg_wdata = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  // [0] compressor_on [1] fan_on [2] valve_on [3] heater_on [4] temp_reached
  // [5] unit_active [7:6] zero
  wire [OUT_BYTES_W-1:0] out_tdata;

  refrigeration_unit_sequencer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file.
  logic signed [7:0] sh_setpoint;
  logic              sh_heat;
  logic              sh_enable;
  timer_t            sh_fan_cycle, sh_max_run, sh_recovery, sh_lead, sh_delay;

  // Shadow copy of the sequencer state.
  logic   st_reached, st_active, st_comp, st_fan, st_valve, st_heater, st_mode;
  timer_t st_fan_cnt, st_start_cnt, st_run_cnt, st_rec_cnt;

  out_word_t expected_drives[$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  logic      quiet = 1'b0;     // set to suppress all idling and stalls
  out_word_t got_word, want_word;

  // Disengage: drop compressor and fan, restart the delay count.
  function void halt_unit();
    st_start_cnt = '0;
    st_active    = 1'b0;
    st_comp      = 1'b0;
    st_fan       = 1'b0;
  endfunction

  // Advance the start delay; start the compressor at its end, or set valve and
  // heater at the lead point.
  function void count_start();
    if (st_start_cnt < sh_delay)
      st_start_cnt = st_start_cnt + 1'b1;
    if (st_start_cnt == sh_delay && !st_reached) begin
      st_comp      = 1'b1;
      st_fan       = 1'b1;
      st_start_cnt = '0;
      st_run_cnt   = '0;
      st_rec_cnt   = '0;
      st_active    = 1'b1;
    end else if (sh_lead <= sh_delay && st_start_cnt == timer_t'(sh_delay - sh_lead)) begin
      st_valve  = sh_heat;
      st_heater = !sh_heat;
    end
  endfunction

  // Predict the drive word caused by one tick and update the shadow state.
  function out_word_t advance_tick(input logic signed [7:0] temp);
    int        t;
    int        sp;
    out_word_t w;
    t  = temp;
    sp = sh_setpoint;
    // Hysteresis band is formed in int, so it never wraps.
    if (!sh_heat) begin
      if (t <= sp)
        st_reached = 1'b1;
      else if (t > sp + TEMP_HYST)
        st_reached = 1'b0;
    end else begin
      if (t >= sp)
        st_reached = 1'b1;
      else if (t < sp - TEMP_HYST)
        st_reached = 1'b0;
    end
    // Fan cycling while the compressor rests.
    if (st_active && !st_comp && st_reached) begin
      if (st_fan_cnt < sh_fan_cycle) begin
        st_fan_cnt = st_fan_cnt + 1'b1;
      end else begin
        st_fan_cnt = '0;
        st_fan     = !st_fan;
      end
    end
    if (sh_enable) begin
      if (sh_heat != st_mode) begin
        st_mode = sh_heat;
        halt_unit();
      end else if (st_active) begin
        if (st_run_cnt < sh_max_run)
          st_run_cnt = st_run_cnt + 1'b1;
        else if (st_rec_cnt < sh_recovery)
          st_rec_cnt = st_rec_cnt + 1'b1;
        else
          count_start();
        if (st_run_cnt == sh_max_run || st_reached)
          st_comp = 1'b0;
      end else begin
        count_start();
      end
    end else if (st_active) begin
      // Disable while engaged: the valve keeps its position.
      halt_unit();
      st_heater = 1'b0;
    end
    w.compressor_on = st_comp;
    w.fan_on        = st_fan;
    w.valve_on      = st_valve;
    w.heater_on     = st_heater;
    w.temp_reached  = st_reached;
    w.unit_active   = st_active;
    return w;
  endfunction

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s", $time, what);
  endtask

  // Write one register while the block is idle and mirror it in the shadow copy.
  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[15:0];
    case (idx)
      REG_SETPOINT:    sh_setpoint  = val[7:0];
      REG_HEAT_MODE:   sh_heat      = val[0];
      REG_RUN_ENABLE:  sh_enable    = val[0];
      REG_FAN_CYCLE:   sh_fan_cycle = val[15:0];
      REG_MAX_RUN:     sh_max_run   = val[15:0];
      REG_RECOVERY:    sh_recovery  = val[15:0];
      REG_VALVE_LEAD:  sh_lead      = val[15:0];
      REG_START_DELAY: sh_delay     = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // Offer one tick word, with random idle cycles ahead of it, and hold it until
  // accepted. Valid stays high afterwards so back-to-back words need no gap.
  task automatic send_tick(input int temp);
    logic signed [7:0] t8;
    t8 = 8'(temp);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = t8;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    expected_drives.push_back(advance_tick(t8));
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_drives.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic int clamp_temp(input int v);
    if (v > 127)
      return 127;
    if (v < -128)
      return -128;
    return v;
  endfunction

  // Pick a temperature: 0 demand side of the band, 1 satisfied side, 2 within
  // four of the setpoint, otherwise anywhere in the full range.
  function automatic int pick_temp(input int kind);
    int sp;
    int r;
    sp = sh_setpoint;
    r  = $urandom_range(0, 5);
    case (kind)
      0:       return clamp_temp(sh_heat ? sp - 3 - r : sp + 3 + r);
      1:       return clamp_temp(sh_heat ? sp + r : sp - r);
      2:       return clamp_temp(sp - 4 + $urandom_range(0, 8));
      default: return int'($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  // Mostly short times so runs, caps and recoveries all come round.
  function automatic int pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return 0;
    if (r < 18)
      return 65535;
    if (r < 28)
      return $urandom_range(13, 400);
    return $urandom_range(1, 12);
  endfunction

  // Result checker: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = out_tdata[5:0];
      if (expected_drives.size() == 0) begin
        flag_error($sformatf("unexpected word %b", out_tdata));
      end else begin
        want_word = expected_drives.pop_front();
        if (got_word.compressor_on !== want_word.compressor_on ||
            got_word.fan_on        !== want_word.fan_on        ||
            got_word.valve_on      !== want_word.valve_on      ||
            got_word.heater_on     !== want_word.heater_on     ||
            got_word.temp_reached  !== want_word.temp_reached  ||
            got_word.unit_active   !== want_word.unit_active   ||
            out_tdata[7:6] !== 2'b00)
          flag_error($sformatf("word mismatch: expected %b actual %b",
                               {2'b00, want_word}, out_tdata));
      end
    end
  end

  // Random backpressure on the result side.
  always @(negedge clk) begin
    if (rst_n)
      out_tready <= quiet || ($urandom_range(0, 99) >= 9);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[refrigeration_unit_sequencer_unit] ERROR");
        $finish;
      end
    end
  end

  // The temperature extremes, then flag edges at the default cooling setpoint.
  task automatic test_hysteresis();
    send_tick(127);
    send_tick(-128);
    send_tick(4);
    send_tick(5);
    send_tick(6);
    send_tick(7);
    send_tick(6);
    send_tick(3);
    settle();
  endtask

  // Setpoint at both ends of its range: the widened band must not wrap.
  task automatic test_setpoint_extremes();
    write_reg(REG_SETPOINT, 127);
    send_tick(127);
    settle();
    write_reg(REG_SETPOINT, -128);
    write_reg(REG_HEAT_MODE, 1);
    send_tick(-128);
    send_tick(127);
    settle();
  endtask

  // Short delay, lead, run cap and recovery, then a satisfied rest with fan cycling.
  task automatic test_start_cycle();
    write_reg(REG_HEAT_MODE, 0);
    write_reg(REG_SETPOINT, 0);
    write_reg(REG_FAN_CYCLE, 0);
    write_reg(REG_MAX_RUN, 3);
    write_reg(REG_RECOVERY, 2);
    write_reg(REG_VALVE_LEAD, 2);
    write_reg(REG_START_DELAY, 4);
    repeat (6) send_tick(20);
    repeat (4) send_tick(-5);
    settle();
  endtask

  // Disable while engaged, change mode while disabled, then enable again.
  task automatic test_enable_and_mode();
    write_reg(REG_RUN_ENABLE, 0);
    send_tick(20);
    send_tick(20);
    settle();
    write_reg(REG_HEAT_MODE, 1);
    write_reg(REG_RUN_ENABLE, 1);
    send_tick(-20);
    send_tick(-20);
    settle();
  endtask

  // Random phases: a full register setting per phase, bursts of ticks mostly aimed
  // at one side of the band, and enable, mode or setpoint flips between bursts.
  task automatic test_random_phases();
    int sent;
    int len;
    int kind;
    int sel;
    int sp;
    for (int p = 0; p < 12; p++) begin
      quiet = (p == 4);
      if (p == 1)
        sp = -128;
      else if (p == 2)
        sp = 127;
      else if ($urandom_range(0, 99) < 20)
        sp = int'($urandom_range(0, 255)) - 128;
      else
        sp = int'($urandom_range(0, 40)) - 20;
      write_reg(REG_SETPOINT, sp);
      write_reg(REG_HEAT_MODE, $urandom_range(0, 1));
      write_reg(REG_RUN_ENABLE, (p == 0 || $urandom_range(0, 99) < 85) ? 1 : 0);
      write_reg(REG_FAN_CYCLE,   p == 0 ? 0 : p == 1 ? 65535 : pick_time());
      write_reg(REG_MAX_RUN,     p == 0 ? 0 : p == 1 ? 65535 : pick_time());
      write_reg(REG_RECOVERY,    p == 0 ? 0 : p == 1 ? 65535 : pick_time());
      write_reg(REG_VALVE_LEAD,  p == 0 ? 0 : p == 1 ? 65535 : pick_time());
      write_reg(REG_START_DELAY, p == 0 ? 0 : p == 1 ? 65535 : pick_time());
      sent = 0;
      while (sent < 122) begin
        len = $urandom_range(5, 40);
        sel = $urandom_range(0, 9);
        kind = (sel < 4) ? 0 : (sel < 7) ? 1 : (sel < 9) ? 2 : 3;
        repeat (len)
          send_tick(pick_temp(($urandom_range(0, 99) < 12) ? 3 : kind));
        sent += len;
        settle();
        sel = $urandom_range(0, 99);
        if (sel < 30)
          write_reg(REG_RUN_ENABLE, !sh_enable);
        else if (sel < 45)
          write_reg(REG_HEAT_MODE, !sh_heat);
        else if (sel < 55)
          write_reg(REG_SETPOINT, int'($urandom_range(0, 40)) - 20);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    // Register defaults and cleared state, as after reset.
    sh_setpoint  = 8'sd4;
    sh_heat      = 1'b0;
    sh_enable    = 1'b1;
    sh_fan_cycle = 16'd300;
    sh_max_run   = 16'd3600;
    sh_recovery  = 16'd300;
    sh_lead      = 16'd10;
    sh_delay     = 16'd180;
    st_reached   = 1'b0;
    st_active    = 1'b0;
    st_comp      = 1'b0;
    st_fan       = 1'b0;
    st_valve     = 1'b0;
    st_heater    = 1'b0;
    st_mode      = 1'b0;
    st_fan_cnt   = '0;
    st_start_cnt = '0;
    st_run_cnt   = '0;
    st_rec_cnt   = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_hysteresis();
    test_setpoint_extremes();
    test_start_cycle();
    test_enable_and_mode();
    test_random_phases();

    // Give any stray word time to show up.
    repeat (10) @(posedge clk);
    if (expected_drives.size() != 0)
      flag_error($sformatf("%0d predicted words never arrived", expected_drives.size()));
    if (mismatches == 0)
      $display("[refrigeration_unit_sequencer_unit] OK");
    else
      $display("[refrigeration_unit_sequencer_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ruseq_pkg.sv
rtl/refrigeration_unit_sequencer_unit.sv
bench/tb_refrigeration_unit_sequencer_unit.sv
